>>> src/sha1_message_digest_assert.svh
// ---------------------------------------------------------------------------
// SHA-1 digest block: assertion macros
// Shared property shorthands, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sha1_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 digest package
// Types, round constants and the controller-to-datapath command bundle.
// ---------------------------------------------------------------------------
package sha1_pkg;

  // Initial chaining value, word 0 in the low slot
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_MARKER = 32'h80000000;

  localparam int unsigned ROUND_LAST = 79;
  localparam int unsigned SCHED_FIRST = 16;
  localparam int unsigned DIGEST_LAST = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_ROUND,
    ST_UPDATE
  } state_t;

  // Source of the word shifted into the block window
  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_MARKER,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } src_t;

  // Round group: selects f and k
  typedef enum logic [1:0] {
    PH_CH,
    PH_PARITY_A,
    PH_MAJ,
    PH_PARITY_B
  } phase_t;

  typedef struct packed {
    logic        shift;
    src_t        src;
    logic        count_add;
    logic        load_vars;
    logic        round;
    phase_t      phase;
    logic        sched_new;
    logic        update_chain;
    logic        capture;
    logic [2:0]  out_idx;
  } cmd_t;

endpackage

>>> src/sha1_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 datapath
// Block window / message schedule, round unit, chaining hash, byte counter
// and the digest holding buffer.
// ---------------------------------------------------------------------------
module sha1_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_data,
  input  logic [2:0]         in_vbytes,
  input  logic               in_last,
  input  sha1_pkg::cmd_t     cmd,
  output logic               in_short,
  output logic [31:0]        out_word
);
  import sha1_pkg::*;

  logic [31:0] win_r   [16];
  logic [31:0] vars_r  [5];
  logic [31:0] chain_r [5];
  logic [31:0] obuf_r  [5];
  logic [60:0] cnt_r;

  logic [2:0]  nbytes;
  logic [31:0] fmt_word;
  logic [63:0] len_bits;
  logic [31:0] shift_word;
  logic [31:0] sched_x;
  logic [31:0] w_cur;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;
  logic [31:0] win_in;

  // Byte count of this item: full word unless final, capped at four
  always_comb begin
    if (!in_last || (in_vbytes > 3'd4)) begin
      nbytes = 3'd4;
    end else begin
      nbytes = in_vbytes;
    end
  end

  assign in_short = in_last && (in_vbytes < 3'd4);

  // Short final word: keep the valid bytes and place the pad marker after them
  always_comb begin
    unique case (nbytes)
      3'd0: begin
        fmt_word = PAD_MARKER;
      end
      3'd1: begin
        fmt_word = {in_data[31:24], 24'h800000};
      end
      3'd2: begin
        fmt_word = {in_data[31:16], 16'h8000};
      end
      3'd3: begin
        fmt_word = {in_data[31:8], 8'h80};
      end
      default: begin
        fmt_word = in_data;
      end
    endcase
  end

  assign len_bits = {cnt_r, 3'b000};

  always_comb begin
    unique case (cmd.src)
      SRC_INPUT:  shift_word = fmt_word;
      SRC_MARKER: shift_word = PAD_MARKER;
      SRC_LEN_HI: shift_word = len_bits[63:32];
      SRC_LEN_LO: shift_word = len_bits[31:0];
      default:    shift_word = '0;
    endcase
  end

  // Schedule word: window holds W[t-16..t-1] in slots 0..15
  assign sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_cur   = cmd.sched_new ? {sched_x[30:0], sched_x[31]} : win_r[0];

  // Round function and constant
  always_comb begin
    unique case (cmd.phase)
      PH_CH: begin
        f_val = (vars_r[1] & vars_r[2]) | (~vars_r[1] & vars_r[3]);
        k_val = K_0;
      end
      PH_PARITY_A: begin
        f_val = vars_r[1] ^ vars_r[2] ^ vars_r[3];
        k_val = K_1;
      end
      PH_MAJ: begin
        f_val = (vars_r[1] & vars_r[2]) | (vars_r[1] & vars_r[3]) |
                (vars_r[2] & vars_r[3]);
        k_val = K_2;
      end
      default: begin
        f_val = vars_r[1] ^ vars_r[2] ^ vars_r[3];
        k_val = K_3;
      end
    endcase
  end

  assign tmp = {vars_r[0][26:0], vars_r[0][31:27]} + f_val + vars_r[4] + k_val + w_cur;

  assign win_in = cmd.shift ? shift_word : w_cur;

  // Block window: message words shift in, rounds rotate or extend it
  always_ff @(posedge clk) begin
    if (cmd.shift || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= win_in;
    end
  end

  // Working variables a..e
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < 5; i++) begin
        vars_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      vars_r[0] <= tmp;
      vars_r[1] <= vars_r[0];
      vars_r[2] <= {vars_r[1][1:0], vars_r[1][31:2]};
      vars_r[3] <= vars_r[2];
      vars_r[4] <= vars_r[3];
    end
  end

  // Chaining hash and message byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= SHA1_IV[i];
      end
      cnt_r <= '0;
    end else begin
      if (cmd.capture) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= SHA1_IV[i];
        end
      end else if (cmd.update_chain) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= chain_r[i] + vars_r[i];
        end
      end
      if (cmd.capture) begin
        cnt_r <= '0;
      end else if (cmd.count_add) begin
        cnt_r <= cnt_r + {58'd0, nbytes};
      end
    end
  end

  // Finished digest, held while it drains
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 5; i++) begin
        obuf_r[i] <= chain_r[i] + vars_r[i];
      end
    end
  end

  assign out_word = obuf_r[cmd.out_idx];

endmodule

>>> src/sha1_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 controller
// Sequences word intake, padding fill, the 80 rounds and the chain update,
// and steps the digest words out.
// ---------------------------------------------------------------------------
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic            in_short,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output logic            out_last,
  output sha1_pkg::cmd_t  cmd
);
  import sha1_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  wcnt_r, wcnt_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;
  logic        mark_r, mark_nxt;
  logic        lenblk_r, lenblk_nxt;
  logic        obusy_r, obusy_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wcnt_r   <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      mark_r   <= 1'b0;
      lenblk_r <= 1'b0;
      obusy_r  <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      wcnt_r   <= wcnt_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      mark_r   <= mark_nxt;
      lenblk_r <= lenblk_nxt;
      obusy_r  <= obusy_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = obusy_r;
  assign out_last  = (oidx_r == 3'(DIGEST_LAST));

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    wcnt_nxt   = wcnt_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    lenblk_nxt = lenblk_r;
    obusy_nxt  = obusy_r;
    oidx_nxt   = oidx_r;

    cmd              = '0;
    cmd.src          = SRC_ZERO;
    cmd.sched_new    = (rnd_r >= 7'(SCHED_FIRST));
    cmd.out_idx      = oidx_r;
    if (rnd_r < 7'd20) begin
      cmd.phase = PH_CH;
    end else if (rnd_r < 7'd40) begin
      cmd.phase = PH_PARITY_A;
    end else if (rnd_r < 7'd60) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PARITY_B;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.shift     = 1'b1;
          cmd.src       = SRC_INPUT;
          cmd.count_add = 1'b1;
          wcnt_nxt      = wcnt_r + 4'd1;
          fin_nxt       = in_last;
          mark_nxt      = in_last && !in_short;
          lenblk_nxt    = in_short && (wcnt_r <= 4'd13);
          if (wcnt_r == 4'd15) begin
            cmd.load_vars = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        // Pad marker if one is owed, then zeros, with the bit length in the last two slots of the closing block
        cmd.shift = 1'b1;
        wcnt_nxt  = wcnt_r + 4'd1;
        if (mark_r) begin
          cmd.src    = SRC_MARKER;
          mark_nxt   = 1'b0;
          lenblk_nxt = (wcnt_r <= 4'd13);
        end else if (lenblk_r && (wcnt_r == 4'd14)) begin
          cmd.src = SRC_LEN_HI;
        end else if (lenblk_r && (wcnt_r == 4'd15)) begin
          cmd.src = SRC_LEN_LO;
        end
        if (wcnt_r == 4'd15) begin
          cmd.load_vars = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUND_LAST)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (fin_r && lenblk_r) begin
          // Closing block: wait for the previous digest to drain
          if (!obusy_r) begin
            cmd.capture = 1'b1;
            fin_nxt     = 1'b0;
            lenblk_nxt  = 1'b0;
            obusy_nxt   = 1'b1;
            oidx_nxt    = '0;
            state_nxt   = ST_IDLE;
          end
        end else begin
          cmd.update_chain = 1'b1;
          if (fin_r) begin
            lenblk_nxt = 1'b1;
            state_nxt  = ST_FILL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Digest word stepping
    if (obusy_r && out_ready) begin
      if (oidx_r == 3'(DIGEST_LAST)) begin
        obusy_nxt = 1'b0;
        oidx_nxt  = '0;
      end else begin
        oidx_nxt = oidx_r + 3'd1;
      end
    end
  end

endmodule

>>> src/sha1_message_digest.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 message digest
// Hashes a big-endian word stream and returns the five digest words.
// ---------------------------------------------------------------------------
// Channel | Direction | tdata (low bit up)                   | tlast
// in_     | sink      | data_word[31:0], valid_bytes[34:32]  | last_item
// out_    | source    | digest_word[31:0], word_index[34:32] | last_word
//
// A word is taken while the block is idle; every sixteenth word starts a compression of
// 80 rounds, one per cycle through the round adder, then a chain update step. The
// final item adds a fill step per remaining block slot and one or two compressions.
// The digest is copied to a holding buffer, so the next message is taken while the
// words drain; a second digest waits in the update step until the first has left.
// Synchronous active-low reset loads the initial vector and clears the count.
// ---------------------------------------------------------------------------
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast
);
  import sha1_pkg::*;

  cmd_t        cmd;
  logic        in_short;
  logic [31:0] out_word;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_short  (in_short),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .cmd       (cmd)
  );

  sha1_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata[31:0]),
    .in_vbytes (in_tdata[34:32]),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .in_short  (in_short),
    .out_word  (out_word)
  );

  assign out_tdata = {5'd0, cmd.out_idx, out_word};

endmodule

>>> src/sha1_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 digest port checker
// Watches the result channel of the top level; bound in below.
// ---------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast
);

  // Stalled transaction holds
  `SHA1_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "out transaction changed under stall")

  // tlast marks the fifth word only
  `SHA1_ASSERT_NOW(a_last_idx, out_tvalid, out_tlast == (out_tdata[34:32] == 3'd4), "tlast does not match word index")

  // Digest words come in order with no gap
  `SHA1_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1), "digest word index skipped")

  // Digests never run into each other
  `SHA1_ASSERT_NEXT(a_gap_after, out_tvalid && out_tready && out_tlast, !out_tvalid, "new digest began right after last word")

endmodule

bind sha1_message_digest sha1_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams whole messages into the digest block and checks the five digest
// words of each one against a behavioral SHA-1 built here. Covers empty and
// partial final words, byte-count saturation, both padding layouts, random
// backpressure on both channels, and a long output stall that fills the
// digest holding stage.
// ---------------------------------------------------------------------------
module tb_top;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_WORDS = 400;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        fin;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  msg_word_t    word_q[$];
  digest_word_t digest_q[$];

  // Behavioral hash state
  logic [31:0] run_hash [0:4];
  logic [31:0] msg_block [0:15];
  logic [60:0] msg_bytes;

  int errors = 0;
  int words_taken = 0;
  int digest_words_seen = 0;
  int digests_done = 0;
  int messages = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Calm window: neither side idles while these words go in
  wire steady = (words_taken >= 150) && (words_taken < 260);

  sha1_message_digest dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_word[31:0], valid_bytes[34:32], zero fill
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // digest_word[31:0], word_index[34:32], zero fill
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Back to the initial vector, empty message
  function automatic void restart_hash();
    for (int i = 0; i < 5; i++) run_hash[i] = SHA1_IV[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_bytes = '0;
  endfunction

  // 80 rounds over msg_block, folded into run_hash
  function automatic void compress_block();
    logic [31:0] sched [0:15];
    logic [31:0] a, b, c, d, e, f, k, w, sum;
    for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
    a = run_hash[0];
    b = run_hash[1];
    c = run_hash[2];
    d = run_hash[3];
    e = run_hash[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15] ^ sched[r & 15];
        w = {w[30:0], w[31]};
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    run_hash[0] += a;
    run_hash[1] += b;
    run_hash[2] += c;
    run_hash[3] += d;
    run_hash[4] += e;
  endfunction

  // Absorb one accepted word; a final word pads, finishes and queues the digest
  function automatic void absorb_word(input logic [31:0] data, input logic [2:0] nb_in,
                                      input logic last);
    int idx;
    int nb;
    int pad;
    logic [31:0] keep;
    logic [63:0] bits;
    digest_word_t dw;
    idx = int'(msg_bytes[5:2]);
    if (!last) begin
      msg_block[idx] = data;
      msg_bytes += 61'd4;
      if (idx == 15) compress_block();
    end else begin
      nb = (nb_in > 3'd4) ? 4 : int'(nb_in);
      msg_bytes += 61'(nb);
      if (nb < 4) begin
        keep = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
        msg_block[idx] = (data & keep) | (32'h80 << (24 - 8 * nb));
        pad = idx;
      end else begin
        msg_block[idx] = data;
        if (idx == 15) begin
          compress_block();
          pad = 0;
        end else begin
          pad = idx + 1;
        end
        msg_block[pad] = PAD_MARKER;
      end
      for (int i = pad + 1; i < 16; i++) msg_block[i] = '0;
      // No room for the length: it goes in an extra block
      if (pad >= 14) begin
        compress_block();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end
      bits = {msg_bytes, 3'b000};
      msg_block[14] = bits[63:32];
      msg_block[15] = bits[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
        dw.word = run_hash[i];
        dw.pos = 3'(i);
        dw.fin = (i == DIGEST_LAST);
        digest_q.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  task automatic queue_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
    msg_word_t mw;
    mw.data = data;
    mw.nbytes = nb;
    mw.last = last;
    word_q.push_back(mw);
    if (last) messages++;
  endtask

  // Mostly short messages, some spanning several blocks; odd counts now and then
  task automatic queue_random_message();
    int nwords;
    int sel;
    logic [2:0] nb;
    sel = $urandom_range(99);
    if (sel < 65) nwords = $urandom_range(1, 20);
    else if (sel < 90) nwords = $urandom_range(21, 40);
    else nwords = $urandom_range(41, 70);
    for (int i = 0; i < nwords - 1; i++) begin
      nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
      queue_word($urandom, nb, 1'b0);
    end
    nb = ($urandom_range(4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    queue_word($urandom, nb, 1'b1);
  endtask

  // Cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words outstanding",
               cycles, digest_q.size());
      $display("** sha1_message_digest: FAILED **");
      $finish;
    end
  end

  // Input driver: predicts on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      restart_hash();
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_word(in_tdata[31:0], in_tdata[34:32], in_tlast);
        words_taken <= words_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (word_q.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, word_q[0].nbytes, word_q[0].data};
          in_tlast <= word_q[0].last;
          void'(word_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output stall once a few digests have gone by
  always @(posedge clk) begin
    if (!hold_done && digests_done == 3) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor and ready generation
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 38);
      if (out_tvalid && out_tready) begin
        digest_words_seen <= digest_words_seen + 1;
        if (out_tlast) digests_done <= digests_done + 1;
        if (digest_q.size() == 0) begin
          flag_mismatch("digest word with none expected", out_tdata[31:0], 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.word)
            flag_mismatch("digest_word", out_tdata[31:0], want.word);
          if (out_tdata[34:32] !== want.pos)
            flag_mismatch("word_index", 32'(out_tdata[34:32]), 32'(want.pos));
          if (out_tlast !== want.fin)
            flag_mismatch("last_word", 32'(out_tlast), 32'(want.fin));
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int directed;
    // Empty message and one-word partial tails; the first two carry all-ones ignored bytes
    queue_word(32'hffffffff, 3'd0, 1'b1);
    queue_word(32'hffffffff, 3'd1, 1'b1);
    queue_word(32'h61626300, 3'd3, 1'b1);
    queue_word(32'h00000000, 3'd2, 1'b1);
    // Final counts above four saturate
    queue_word(32'hdeadbeef, 3'd7, 1'b1);
    queue_word(32'h89abcdef, 3'd5, 1'b1);
    // Short counts on non-final words count as four
    queue_word(32'h12345678, 3'd0, 1'b0);
    queue_word(32'h9abcdef0, 3'd3, 1'b0);
    queue_word(32'h00000000, 3'd4, 1'b1);
    // Pad marker lands in slot 14: length needs a second block
    for (int i = 0; i < 13; i++)
      queue_word((i % 2 == 0) ? 32'hffffffff : 32'h00000000, 3'(4 + (i % 4)), 1'b0);
    queue_word(32'ha5a55a5a, 3'd4, 1'b1);
    directed = word_q.size();
    while (word_q.size() - directed < RANDOM_WORDS) queue_random_message();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d input words; %0d digest words compared.",
             messages, words_taken, digest_words_seen);
    $display("Included empty and partial tails, two-block padding and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("** sha1_message_digest: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** sha1_message_digest: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sha1_pkg.sv
src/sha1_dp.sv
src/sha1_ctrl.sv
src/sha1_message_digest.sv
src/sha1_checker.sv
dv/tb_top.sv
